// ----- rtl/frame_audio_level_stats_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frame audio level meter
// Clocked, reset-qualified property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_AUDIO_LEVEL_STATS_UNIT_MACROS_SVH
`define FRAME_AUDIO_LEVEL_STATS_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FALS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a property in the same cycle.
`define FALS_ASSERT_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |-> (prop)) else $error(msg);

`endif

// ----- rtl/fals_pkg.sv -----
// ----------------------------------------------------------------------------
// fals_pkg
// Widths, reset values and shared types of the frame audio level meter.
// ----------------------------------------------------------------------------
package fals_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_W      = 16;
  // Sample counter must hold 2^LEN_W for a zero length register.
  localparam int unsigned CNT_W      = LEN_W + 1;
  localparam int unsigned SUM_W      = SAMPLE_W + LEN_W + 1;
  localparam int unsigned MAG_W      = SAMPLE_W + LEN_W;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned DVD_W      = MAG_W;
  localparam int unsigned QUO_W      = DVD_W - LEN_W;
  localparam int unsigned STEP_W     = $clog2(QUO_W);
  localparam int unsigned OUT_W      = FRAME_W + 4 * SAMPLE_W;

  localparam logic [LEN_W-1:0]    LEN_RESET  = LEN_W'(19705);
  localparam logic [SAMPLE_W-1:0] SMP_MAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_MIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_SUM,
    ST_DIV_SUM,
    ST_DIV_MAG,
    ST_EMIT
  } fals_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/fals_divider.sv -----
// ----------------------------------------------------------------------------
// fals_divider
// Restoring unsigned divider, one quotient bit per cycle. The dividend must
// be below divisor * 2^QUO_W so the quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module fals_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fals_pkg::DVD_W-1:0]    dividend_i,
  input  logic [fals_pkg::CNT_W-1:0]    divisor_i,
  output fals_pkg::div_stat_t           stat_o,
  output logic [fals_pkg::QUO_W-1:0]    quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [fals_pkg::STEP_W-1:0]   step_q, step_d;
  logic [fals_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [fals_pkg::CNT_W-1:0]    div_q, div_d;
  logic [fals_pkg::QUO_W-1:0]    bits_q, bits_d;
  logic [fals_pkg::CNT_W:0]      trial;

  assign trial = {rem_q, bits_q[fals_pkg::QUO_W-1]} - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    div_d  = div_q;
    bits_d = bits_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      // Upper half is below the divisor, so it seeds the remainder directly.
      rem_d  = {1'b0, dividend_i[fals_pkg::DVD_W-1:fals_pkg::QUO_W]};
      bits_d = dividend_i[fals_pkg::QUO_W-1:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[fals_pkg::CNT_W]) begin
        rem_d = trial[fals_pkg::CNT_W-1:0];
      end else begin
        rem_d = {rem_q[fals_pkg::CNT_W-2:0], bits_q[fals_pkg::QUO_W-1]};
      end
      bits_d = {bits_q[fals_pkg::QUO_W-2:0], ~trial[fals_pkg::CNT_W]};
      step_d = step_q + 1'b1;
      if (step_q == fals_pkg::STEP_W'(fals_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    bits_q <= bits_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = bits_q;

endmodule

// ----- rtl/frame_audio_level_stats_unit.sv -----
// ----------------------------------------------------------------------------
// frame_audio_level_stats_unit
// Per-frame peak, swing, mean level and mean magnitude meter for signed audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed sample per item in tdata[15:0]. Every item
//   updates the running minimum, maximum, sum and sum of magnitudes; the item
//   that completes a frame of frame_length samples (zero means 65536) closes
//   it and yields one result item on m_axis.
//   cfg_* writes frame_length; the new length applies to the open frame at
//   once and writes never clear the accumulators or the frame counter.
//   Items that do not close a frame are taken back to back. After a closing
//   item no sample is taken until its result is in the output register:
//   both means come from one shared restoring divider that yields one
//   quotient bit per cycle, run back to back.
//   s_axis_tready stays low while the divider works and while a finished
//   result waits for the output register to free up; a result already in
//   the output register does not block samples that keep a frame open.
//   When the receiver stalls, m_axis holds its item unchanged.
//   Reset sets frame_length to 19705, clears the frame counter and empties
//   the accumulators; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module frame_audio_level_stats_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fals_pkg::LEN_W-1:0]   cfg_data_i,    // frame_length
  // sample stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [fals_pkg::SAMPLE_W-1:0] s_axis_tdata, // [15:0] sample
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] frame_index, [47:32] peak, [63:48] swing, [79:64] mean_level,
  // [95:80] mean_magnitude
  output logic [fals_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int unsigned SW = fals_pkg::SAMPLE_W;

  fals_pkg::fals_state_e state_q, state_d;

  logic [fals_pkg::LEN_W-1:0]    len_q;
  logic signed [SW-1:0]          lo_q, hi_q;
  logic signed [fals_pkg::SUM_W-1:0] sum_q;
  logic [fals_pkg::MAG_W-1:0]    mag_q;
  logic [fals_pkg::CNT_W-1:0]    cnt_q;
  logic [fals_pkg::FRAME_W-1:0]  frame_q;

  // frame snapshot taken at close
  logic signed [SW-1:0]          snap_lo_q, snap_hi_q;
  logic signed [fals_pkg::SUM_W-1:0] snap_sum_q;
  logic [fals_pkg::MAG_W-1:0]    snap_mag_q;
  logic [fals_pkg::CNT_W-1:0]    snap_cnt_q;
  logic [fals_pkg::FRAME_W-1:0]  snap_idx_q;
  logic [SW-1:0]                 mean_lvl_q;
  logic [SW-1:0]                 mean_mag_q;

  logic                          out_valid_q;
  logic [fals_pkg::OUT_W-1:0]    out_data_q;

  logic signed [SW-1:0]          smp;
  logic signed [SW:0]            smp_x;
  logic [SW:0]                   smp_abs;
  logic signed [SW-1:0]          lo_new, hi_new;
  logic signed [fals_pkg::SUM_W-1:0] sum_new;
  logic [fals_pkg::MAG_W-1:0]    mag_new;
  logic [fals_pkg::CNT_W-1:0]    cnt_new, target;
  logic                          in_acc, closes;

  logic [fals_pkg::SUM_W-1:0]    sum_abs;
  logic                          div_start;
  logic [fals_pkg::DVD_W-1:0]    div_dividend;
  fals_pkg::div_stat_t           div_stat;
  logic [fals_pkg::QUO_W-1:0]    div_quot;
  logic                          cap_lvl, cap_mag, out_load;

  logic signed [SW:0]            lo_x, hi_x;
  logic [SW:0]                   lo_abs, hi_abs, peak_w;
  logic [SW-1:0]                 swing_w;

  // ---------------- sample path ----------------
  assign smp     = $signed(s_axis_tdata[SW-1:0]);
  assign smp_x   = {smp[SW-1], smp};
  assign smp_abs = smp_x[SW] ? (SW+1)'(-smp_x) : smp_x;
  assign lo_new  = (smp < lo_q) ? smp : lo_q;
  assign hi_new  = (smp > hi_q) ? smp : hi_q;
  assign sum_new = sum_q + fals_pkg::SUM_W'(smp);
  assign mag_new = mag_q + fals_pkg::MAG_W'(smp_abs);
  assign cnt_new = cnt_q + 1'b1;
  assign target  = (len_q == '0) ? {1'b1, {fals_pkg::LEN_W{1'b0}}} : {1'b0, len_q};

  assign s_axis_tready = (state_q == fals_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign closes        = (cnt_new >= target);
  assign cfg_ready_o   = 1'b1;

  // ---------------- sequencer ----------------
  assign sum_abs      = snap_sum_q[fals_pkg::SUM_W-1] ? -snap_sum_q : snap_sum_q;
  assign div_dividend = (state_q == fals_pkg::ST_START_SUM) ?
                        sum_abs[fals_pkg::DVD_W-1:0] : snap_mag_q;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    cap_lvl   = 1'b0;
    cap_mag   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      fals_pkg::ST_IDLE: begin
        if (in_acc && closes) begin
          state_d = fals_pkg::ST_START_SUM;
        end
      end
      fals_pkg::ST_START_SUM: begin
        div_start = 1'b1;
        state_d   = fals_pkg::ST_DIV_SUM;
      end
      fals_pkg::ST_DIV_SUM: begin
        if (div_stat.done) begin
          cap_lvl   = 1'b1;
          div_start = 1'b1;
          state_d   = fals_pkg::ST_DIV_MAG;
        end
      end
      fals_pkg::ST_DIV_MAG: begin
        if (div_stat.done) begin
          cap_mag = 1'b1;
          state_d = fals_pkg::ST_EMIT;
        end
      end
      fals_pkg::ST_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = fals_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fals_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fals_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  fals_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (snap_cnt_q),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // ---------------- accumulators ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= fals_pkg::LEN_RESET;
      lo_q    <= $signed(fals_pkg::SMP_MAX);
      hi_q    <= $signed(fals_pkg::SMP_MIN);
      sum_q   <= '0;
      mag_q   <= '0;
      cnt_q   <= '0;
      frame_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
      end
      if (in_acc) begin
        if (closes) begin
          lo_q    <= $signed(fals_pkg::SMP_MAX);
          hi_q    <= $signed(fals_pkg::SMP_MIN);
          sum_q   <= '0;
          mag_q   <= '0;
          cnt_q   <= '0;
          frame_q <= frame_q + 1'b1;
        end else begin
          lo_q  <= lo_new;
          hi_q  <= hi_new;
          sum_q <= sum_new;
          mag_q <= mag_new;
          cnt_q <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && closes) begin
      snap_lo_q  <= lo_new;
      snap_hi_q  <= hi_new;
      snap_sum_q <= sum_new;
      snap_mag_q <= mag_new;
      snap_cnt_q <= cnt_new;
      snap_idx_q <= frame_q;
    end
    if (cap_lvl) begin
      mean_lvl_q <= snap_sum_q[fals_pkg::SUM_W-1] ? SW'(-div_quot) : div_quot;
    end
    if (cap_mag) begin
      mean_mag_q <= div_quot;
    end
  end

  // ---------------- output register ----------------
  assign lo_x    = {snap_lo_q[SW-1], snap_lo_q};
  assign hi_x    = {snap_hi_q[SW-1], snap_hi_q};
  assign lo_abs  = lo_x[SW] ? (SW+1)'(-lo_x) : lo_x;
  assign hi_abs  = hi_x[SW] ? (SW+1)'(-hi_x) : hi_x;
  assign peak_w  = (lo_abs > hi_abs) ? lo_abs : hi_abs;
  assign swing_w = SW'(snap_hi_q - snap_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {mean_mag_q, mean_lvl_q, swing_w, peak_w[SW-1:0], snap_idx_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/fals_checker.sv -----
// ----------------------------------------------------------------------------
// fals_checker
// Port-level checks of the frame audio level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_audio_level_stats_unit_macros.svh"

module fals_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_ready_o,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [fals_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic [15:0] peak_v, lvl_v, mag_v;
  logic [16:0] lvl_abs;

  assign peak_v  = m_axis_tdata[47:32];
  assign lvl_v   = m_axis_tdata[79:64];
  assign mag_v   = m_axis_tdata[95:80];
  assign lvl_abs = lvl_v[15] ? (17'h10000 - {1'b0, lvl_v}) : {1'b0, lvl_v};

  // A stalled result keeps its payload.
  `FALS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Mean magnitude bounds the magnitude of the mean (32768 encodes as 0x8000).
  `FALS_ASSERT_IMPLIES(a_mag_ge_lvl, m_axis_tvalid, ((mag_v == 16'h8000) || ({1'b0, mag_v} >= lvl_abs)), "mean magnitude below mean level")

  // Peak bounds the mean magnitude.
  `FALS_ASSERT_IMPLIES(a_peak_ge_mag, m_axis_tvalid, ((peak_v == 16'h8000) || ((mag_v != 16'h8000) && (peak_v >= mag_v))), "peak below mean magnitude")

  // The sample side stalls only after an item was offered to it.
  `FALS_ASSERT_IMPLIES(a_stall_cause, $fell(s_axis_tready), $past(s_axis_tvalid), "sample side stalled without an item")

  // Register writes are never back-pressured.
  `FALS_ASSERT(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

bind frame_audio_level_stats_unit fals_checker u_fals_checker (.*);
